FILE: src/pact_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and defaults for the position and profit table
package pact_pkg;

	localparam int DEF_NUM_TRADERS = 16;
	localparam int DEF_NUM_BOOKS   = 16;

	// action codes
	localparam logic [1:0] ACT_FILL  = 2'd0;
	localparam logic [1:0] ACT_MARK  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	// multiplier run lengths in bits
	localparam logic [6:0] MUL_LEN_WIDE = 7'd64;
	localparam logic [6:0] MUL_LEN_QTY  = 7'd32;

	// one table entry
	typedef struct packed {
		logic        valid;
		logic [63:0] net;
		logic [63:0] avg;
		logic [63:0] pnl;
		logic [63:0] mark;
	} entry_t;

	// control word for the serial multiplier
	typedef struct packed {
		logic       start;
		logic       clr;
		logic       sgn_top;
		logic [6:0] len;
	} mul_ctl_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DECIDE,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_CMUL,
		ST_WRITE,
		ST_OUT
	} state_t;

endpackage

FILE: src/pact_mul.sv
`timescale 1ns / 1ps
// bit-serial shift-and-add multiplier with 128-bit accumulator
module pact_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  pact_pkg::mul_ctl_t ctl,
	input  logic [63:0]       mcand,
	input  logic [63:0]       mplier,
	output logic [127:0]      acc,
	output logic              done
);
	import pact_pkg::*;

	logic         busy_q;
	logic         done_q;
	logic [6:0]   cnt_q;
	logic [127:0] mc_q;
	logic [63:0]  mp_q;
	logic [127:0] acc_q;
	logic         sgn_q;
	logic [127:0] term;

	// top bit of a signed multiplier carries negative weight
	assign term = (sgn_q && (cnt_q == 7'd0)) ? (~mc_q + 128'd1) : mc_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.len - 7'd1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: one multiplier bit a cycle
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mc_q  <= {{64{mcand[63]}}, mcand};
			mp_q  <= mplier;
			sgn_q <= ctl.sgn_top;
			if (ctl.clr)
				acc_q <= '0;
		end else if (busy_q) begin
			if (mp_q[0])
				acc_q <= acc_q + term;
			mc_q <= {mc_q[126:0], 1'b0};
			mp_q <= {1'b0, mp_q[63:1]};
		end
	end

	assign acc  = acc_q;
	assign done = done_q;
endmodule

FILE: src/pact_div.sv
`timescale 1ns / 1ps
// bit-serial restoring divider, signed 128-bit by signed 64-bit, on magnitudes
module pact_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	output logic [63:0]  quot,
	output logic         done
);
	import pact_pkg::*;

	logic         busy_q;
	logic         done_q;
	logic [6:0]   cnt_q;
	logic [127:0] nm_q;
	logic [63:0]  dm_q;
	logic [63:0]  rem_q;
	logic [63:0]  q_q;
	logic         neg_q;
	logic [63:0]  r2;
	logic         ge;

	// remainder is kept to 64 bits, its shifted top bit drops out
	assign r2 = {rem_q[62:0], nm_q[127]};
	assign ge = (r2 >= dm_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd127;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			nm_q  <= num[127] ? (~num + 128'd1) : num;
			dm_q  <= den[63] ? (~den + 64'd1) : den;
			neg_q <= num[127] ^ den[63];
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			nm_q  <= {nm_q[126:0], 1'b0};
			rem_q <= ge ? (r2 - dm_q) : r2;
			q_q   <= {q_q[62:0], ge};
		end
	end

	assign quot = neg_q ? (~q_q + 64'd1) : q_q;
	assign done = done_q;
endmodule

FILE: src/position_avg_cost_pnl_table.sv
`timescale 1ns / 1ps
// top level: position table with average cost and realised profit tracking
// Usage: one input word (action, trader, book, side, price, quantity) is taken
// when in_valid is high and in_stall low; exactly one result word (found and
// the entry's fields) follows on the out channel under out_valid / out_stall.
// Items are handled one at a time. Steps from acceptance to the result:
//   query, mark or out-of-range index: table read, decide, write, output
//   reducing, closing or flipping fill: a 64-bit serial product before the write
//   opening fill: a 64-bit and then a 32-bit serial product and, when the
//   total quantity is non-zero, the 128-by-64 bit serial divider, one
//   quotient bit a cycle, before the write.
// A new word can be taken in the cycle after the previous result is
// registered. The table is one single-port memory with registered read; each
// item does one read and at most one write of its row.
// After reset the block sweeps all NUM_TRADERS*NUM_BOOKS rows of the table,
// one row a cycle, writing zero entries; in_stall is high during the sweep.
// When the receiver stalls, the result waits in the output register and the
// block still takes the next word, which waits before its own result until
// the register is free.
module position_avg_cost_pnl_table #(
	parameter int NUM_TRADERS = pact_pkg::DEF_NUM_TRADERS,
	parameter int NUM_BOOKS   = pact_pkg::DEF_NUM_BOOKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [3:0]  trader,
	input  logic [3:0]  book,
	input  logic        side,
	input  logic [63:0] price,
	input  logic [31:0] quantity,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [63:0] net_qty,
	output logic [63:0] average_cost,
	output logic [63:0] realized_profit,
	output logic [63:0] current_mark
);
	import pact_pkg::*;

	localparam int DEPTH = NUM_TRADERS * NUM_BOOKS;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t state_q, state_d;

	// table memory
	entry_t mem [DEPTH];
	entry_t rd_q;
	logic          mem_we;
	logic [IW-1:0] mem_addr;
	entry_t        mem_wdata;

	// captured word
	logic [1:0]    act_q;
	logic [IW-1:0] ix_q;
	logic          side_q;
	logic [63:0]   price_q;
	logic [31:0]   qty_q;
	logic          inrange_q;
	logic [IW-1:0] clr_q;
	logic [63:0]   total_q;
	logic          we_q;
	entry_t        new_q;
	logic          out_valid_q;
	entry_t        out_q;

	logic          accept;
	logic [31:0]   ix_full;
	logic          inrange;

	// decision terms from the read entry
	logic [63:0] qty64, delta, absn, closing, diff, newnet, prod, signed_prod;
	logic        net_pos, delta_pos, opening, is_fill;

	mul_ctl_t     mul_ctl;
	logic [63:0]  mul_mcand, mul_mplier;
	logic [127:0] mul_acc;
	logic         mul_done;
	logic         div_start;
	logic [63:0]  div_quot;
	logic         div_done;

	pact_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.mcand  (mul_mcand),
		.mplier (mul_mplier),
		.acc    (mul_acc),
		.done   (mul_done)
	);

	pact_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mul_acc),
		.den    (total_q),
		.quot   (div_quot),
		.done   (div_done)
	);

	// index and range check
	assign ix_full = 32'(trader) * 32'(NUM_BOOKS) + 32'(book);
	assign inrange = (32'(trader) < 32'(NUM_TRADERS)) && (32'(book) < 32'(NUM_BOOKS));
	assign accept  = in_valid && !in_stall;

	// fill arithmetic terms
	assign qty64       = {32'd0, qty_q};
	assign delta       = side_q ? (64'd0 - qty64) : qty64;
	assign absn        = rd_q.net[63] ? (64'd0 - rd_q.net) : rd_q.net;
	assign net_pos     = (rd_q.net != 64'd0) && !rd_q.net[63];
	assign delta_pos   = (delta != 64'd0) && !delta[63];
	assign opening     = (rd_q.net == 64'd0) || (net_pos == delta_pos);
	assign closing     = (absn[63] || (absn < qty64)) ? absn : qty64;
	assign diff        = price_q - rd_q.avg;
	assign newnet      = rd_q.net + delta;
	assign prod        = mul_acc[63:0];
	assign signed_prod = net_pos ? prod : (64'd0 - prod);
	assign is_fill     = (act_q == ACT_FILL);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == IW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_READ;
			ST_READ:   state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (!inrange_q || !is_fill)
					state_d = ST_WRITE;
				else if (opening)
					state_d = ST_MUL1;
				else
					state_d = ST_CMUL;
			end
			ST_MUL1:   if (mul_done) state_d = ST_MUL2;
			ST_MUL2:   if (mul_done) state_d = (total_q == 64'd0) ? ST_WRITE : ST_DIV;
			ST_DIV:    if (div_done) state_d = ST_WRITE;
			ST_CMUL:   if (mul_done) state_d = ST_WRITE;
			ST_WRITE:  state_d = ST_OUT;
			ST_OUT:    if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall    = (state_q != ST_IDLE);
		mem_we      = 1'b0;
		mem_addr    = ix_q;
		mem_wdata   = new_q;
		mul_ctl     = '0;
		mul_mcand   = rd_q.avg;
		mul_mplier  = absn;
		div_start   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			ST_DECIDE: begin
				if (inrange_q && is_fill) begin
					mul_ctl.start = 1'b1;
					mul_ctl.clr   = 1'b1;
					mul_ctl.len   = MUL_LEN_WIDE;
					if (opening) begin
						mul_ctl.sgn_top = 1'b1;
					end else begin
						mul_mcand  = diff;
						mul_mplier = closing;
					end
				end
			end
			ST_MUL1: begin
				mul_mcand  = price_q;
				mul_mplier = qty64;
				mul_ctl.len = MUL_LEN_QTY;
				mul_ctl.start = mul_done;
			end
			ST_MUL2:  div_start = mul_done && (total_q != 64'd0);
			ST_WRITE: mem_we = we_q;
			default:  ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + IW'(1);
			if (state_q == ST_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		rd_q <= mem[mem_addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= action;
			ix_q      <= ix_full[IW-1:0];
			side_q    <= side;
			price_q   <= price;
			qty_q     <= quantity;
			inrange_q <= inrange;
		end
		unique case (state_q)
			ST_DECIDE: begin
				total_q <= absn + qty64;
				new_q   <= rd_q;
				we_q    <= 1'b0;
				if (!inrange_q) begin
					new_q <= '0;
				end else if (is_fill) begin
					new_q.valid <= 1'b1;
					new_q.net   <= newnet;
					new_q.mark  <= price_q;
					we_q        <= 1'b1;
				end else if (act_q == ACT_MARK && rd_q.valid) begin
					new_q.mark <= price_q;
					we_q       <= 1'b1;
				end
			end
			ST_MUL2: if (mul_done && total_q == 64'd0) new_q.avg <= '0;
			ST_DIV:  if (div_done) new_q.avg <= div_quot;
			ST_CMUL: begin
				if (mul_done) begin
					new_q.pnl <= rd_q.pnl + signed_prod;
					if (newnet == 64'd0)
						new_q.avg <= '0;
					else if (((newnet != 64'd0) && !newnet[63]) != net_pos)
						new_q.avg <= price_q;
				end
			end
			ST_OUT: if (!out_valid_q || !out_stall) out_q <= new_q;
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign found           = out_q.valid;
	assign net_qty         = out_q.net;
	assign average_cost    = out_q.avg;
	assign realized_profit = out_q.pnl;
	assign current_mark    = out_q.mark;
endmodule

FILE: tb/sv/tb_position_checker.sv
`timescale 1ns / 1ps
// checker: watches both channels, predicts each result word and compares it
module tb_position_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  action,
	input  logic [3:0]  trader,
	input  logic [3:0]  book,
	input  logic        side,
	input  logic [63:0] price,
	input  logic [31:0] quantity,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        found,
	input  logic [63:0] net_qty,
	input  logic [63:0] average_cost,
	input  logic [63:0] realized_profit,
	input  logic [63:0] current_mark,
	output int          fail_count,
	output int          pending_count
);
	import pact_pkg::*;

	// local copy of the position table
	entry_t book_table [256];
	entry_t expected_q [$];

	function automatic logic [63:0] mag64(logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	// signed 128 / signed 64, truncating toward zero, low 64 bits kept
	function automatic logic [63:0] avg_divide(logic [127:0] num, logic [63:0] den);
		logic         nneg;
		logic [127:0] nm;
		logic [63:0]  dm;
		logic [127:0] q;
		nneg = num[127];
		nm = nneg ? (128'd0 - num) : num;
		dm = mag64(den);
		q = nm / {64'd0, dm};
		return (nneg != den[63]) ? (64'd0 - q[63:0]) : q[63:0];
	endfunction

	// apply one accepted word to the local table and return the result word
	function automatic entry_t position_update(logic [1:0] act, logic [3:0] tr, logic [3:0] bk,
			logic sd, logic [63:0] px, logic [31:0] qty);
		entry_t       e;
		logic [7:0]   ix;
		logic [63:0]  delta, absn, total, closing, newnet, dir;
		logic [127:0] prod_a, prod_b, sum;
		logic         opening, longpos;
		ix = {tr, bk};
		e = book_table[ix];
		if (act == ACT_FILL) begin
			delta = sd ? (64'd0 - {32'd0, qty}) : {32'd0, qty};
			absn = mag64(e.net);
			opening = (e.net == 0) ||
				((e.net != 0 && !e.net[63]) == (delta != 0 && !delta[63]));
			if (opening) begin
				total = absn + {32'd0, qty};
				prod_a = $signed({{64{absn[63]}}, absn}) * $signed({{64{e.avg[63]}}, e.avg});
				prod_b = $signed({96'd0, qty}) * $signed({{64{px[63]}}, px});
				sum = prod_a + prod_b;
				e.avg = (total == 0) ? 64'd0 : avg_divide(sum, total);
				e.net = e.net + delta;
			end else begin
				closing = (absn[63] || absn < {32'd0, qty}) ? absn : {32'd0, qty};
				longpos = (e.net != 0) && !e.net[63];
				dir = longpos ? 64'd1 : {64{1'b1}};
				newnet = e.net + delta;
				e.pnl = e.pnl + dir * closing * (px - e.avg);
				e.net = newnet;
				if (newnet == 0)
					e.avg = 64'd0;
				else if (((newnet != 0) && !newnet[63]) != longpos)
					e.avg = px;
			end
			e.mark = px;
			e.valid = 1'b1;
		end else if (act == ACT_MARK && e.valid) begin
			e.mark = px;
		end
		book_table[ix] = e;
		if (!e.valid)
			e = '0;
		return e;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// predict on input words, compare on output words
	always @(posedge clk or negedge arst_n) begin
		entry_t w;
		if (!arst_n) begin
			foreach (book_table[i])
				book_table[i] = '0;
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (in_valid && !in_stall)
				expected_q.push_back(position_update(action, trader, book, side, price,
					quantity));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected word", {63'd0, found}, 64'd0);
				end else begin
					w = expected_q.pop_front();
					if (found !== w.valid)
						report_mismatch("found", {63'd0, found}, {63'd0, w.valid});
					if (net_qty !== w.net)
						report_mismatch("net_qty", net_qty, w.net);
					if (average_cost !== w.avg)
						report_mismatch("average_cost", average_cost, w.avg);
					if (realized_profit !== w.pnl)
						report_mismatch("realized_profit", realized_profit, w.pnl);
					if (current_mark !== w.mark)
						report_mismatch("current_mark", current_mark, w.mark);
				end
			end
		end
		pending_count = expected_q.size();
	end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus and verdict for the position table
module tb_top;
	import pact_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = ACT_QUERY;
	logic [3:0]  trader = '0;
	logic [3:0]  book = '0;
	logic        side = 1'b0;
	logic [63:0] price = '0;
	logic [31:0] quantity = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        found;
	logic [63:0] net_qty, average_cost, realized_profit, current_mark;
	int          fail_count, pending_count;
	int          cycle_count = 0;
	bit          long_hold = 1'b0;
	bit          hold_done = 1'b0;

	localparam int CYCLE_LIMIT = 3000000;

	position_avg_cost_pnl_table dut (.*);
	tb_position_checker checker_i (.*);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver stall pattern, with one long hold-off
	always @(posedge clk) begin
		int mode;
		if (long_hold) begin
			out_stall <= 1'b1;
		end else begin
			mode = (cycle_count / 4000) % 3;
			if (mode == 0)
				out_stall <= 1'b0;
			else if (mode == 1)
				out_stall <= ($urandom_range(0, 3) == 0);
			else
				out_stall <= ($urandom_range(0, 1) == 0);
		end
	end

	initial begin
		repeat (800) @(posedge clk);
		long_hold <= 1'b1;
		repeat (600) @(posedge clk);
		long_hold <= 1'b0;
		hold_done <= 1'b1;
	end

	// present one word and wait for it to be taken
	task automatic send_word(logic [1:0] a, logic [3:0] t, logic [3:0] b, logic s,
			logic [63:0] p, logic [31:0] q);
		action <= a; trader <= t; book <= b; side <= s; price <= p; quantity <= q;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid, then wait for a clock edge
	task automatic pause_word();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand_price();
		case ($urandom_range(0, 5))
			0: return {$urandom, $urandom};
			1: return 64'h8000_0000_0000_0000;
			2: return 64'h7fff_ffff_ffff_ffff;
			default: return 64'($signed($urandom_range(0, 20000)) - 10000);
		endcase
	endfunction

	function automatic logic [31:0] rand_qty();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'd0;
			2: return 32'hffff_ffff;
			default: return $urandom_range(1, 200);
		endcase
	endfunction

	initial begin
		int burst;
		logic [1:0] a;
		logic [3:0] t, b;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: missing entries, extremes, flips, closes, zero quantity
		send_word(ACT_QUERY, 4'd0, 4'd0, 1'b0, 64'd0, 32'd0);
		send_word(ACT_MARK, 4'd0, 4'd0, 1'b0, 64'd55, 32'd0);
		send_word(2'd3, 4'd15, 4'd15, 1'b1, 64'd0, 32'd0);
		send_word(ACT_FILL, 4'd0, 4'd0, 1'b0, 64'd100, 32'd10);
		send_word(ACT_FILL, 4'd0, 4'd0, 1'b0, 64'd200, 32'd30);
		send_word(ACT_FILL, 4'd0, 4'd0, 1'b0, 64'd7, 32'd0);
		send_word(ACT_FILL, 4'd0, 4'd0, 1'b1, 64'd300, 32'd15);
		send_word(ACT_FILL, 4'd0, 4'd0, 1'b1, 64'd50, 32'd40);
		send_word(ACT_FILL, 4'd0, 4'd0, 1'b1, 64'd60, 32'd0);
		send_word(ACT_FILL, 4'd0, 4'd0, 1'b0, 64'd10, 32'd15);
		send_word(ACT_MARK, 4'd0, 4'd0, 1'b0, 64'h8000_0000_0000_0000, 32'd0);
		send_word(ACT_QUERY, 4'd0, 4'd0, 1'b0, 64'd0, 32'd0);
		send_word(ACT_FILL, 4'd15, 4'd15, 1'b1, 64'h7fff_ffff_ffff_ffff, 32'hffff_ffff);
		send_word(ACT_FILL, 4'd15, 4'd15, 1'b1, 64'h8000_0000_0000_0000, 32'hffff_ffff);
		send_word(ACT_FILL, 4'd15, 4'd15, 1'b0, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
		send_word(ACT_FILL, 4'd15, 4'd0, 1'b0, 64'd0, 32'd0);
		send_word(ACT_QUERY, 4'd15, 4'd0, 1'b1, 64'd0, 32'd0);
		send_word(ACT_FILL, 4'd0, 4'd15, 1'b0, 64'h8000_0000_0000_0000, 32'hffff_ffff);
		send_word(ACT_FILL, 4'd0, 4'd15, 1'b0, 64'h8000_0000_0000_0000, 32'hffff_ffff);
		send_word(ACT_FILL, 4'd0, 4'd15, 1'b1, 64'h7fff_ffff_ffff_ffff, 32'd1);
		pause_word();

		// random bursts on a few hot rows so positions build and unwind
		for (int n = 0; n < 1900; ) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst; k++) begin
				a = ($urandom_range(0, 9) < 6) ? ACT_FILL : 2'($urandom_range(1, 3));
				if ($urandom_range(0, 4) == 0) begin
					t = 4'($urandom); b = 4'($urandom);
				end else begin
					t = 4'($urandom_range(0, 2)); b = 4'($urandom_range(0, 2));
				end
				send_word(a, t, b, 1'($urandom), rand_price(), rand_qty());
				n++;
			end
			pause_word();
			if (n > 950 && n < 965 && hold_done) begin
				while (pending_count != 0) @(posedge clk);
			end else begin
				repeat ($urandom_range(0, 6)) @(posedge clk);
			end
		end

		while (pending_count != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
